// ===== src/mvna_pkg.sv =====
// ============================================================================
// Mesh vertex normal accumulator package
// Shared constants, state types and the result structure of the normaliser.
// ============================================================================
package mvna_pkg;

  // Default configuration of the block.
  localparam int unsigned MaxVerticesDef    = 1024;
  localparam int unsigned CoordBitsDef      = 16;
  localparam int unsigned SumBitsDef        = 48;
  localparam int unsigned NormalFracBitsDef = 14;

  // Fixed widths of the interface fields.
  localparam int unsigned OpBits    = 2;
  localparam int unsigned IndexBits = 10;
  localparam int unsigned PosBits   = 16;
  localparam int unsigned OutBits   = 16;

  // Magnitudes are scaled so that the largest lies in [2^29, 2^30).
  localparam int unsigned NormBits = 30;
  localparam int unsigned SqBits   = 2 * NormBits + 2;
  localparam int unsigned RootBits = NormBits + 1;

  // Item opcodes.
  localparam logic [OpBits-1:0] OpLoad     = 2'd0;
  localparam logic [OpBits-1:0] OpTriangle = 2'd1;
  localparam logic [OpBits-1:0] OpRead     = 2'd2;

  // Sequencer of the top level.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TRI_RD,
    ST_TRI_EDGE,
    ST_TRI_MUL,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RD_SUM,
    ST_RD_START,
    ST_RD_WAIT,
    ST_DONE
  } mvna_state_e;

  // Sequencer of the normaliser.
  typedef enum logic [2:0] {
    NS_IDLE,
    NS_NORM,
    NS_SQ,
    NS_SQRT,
    NS_DIV_SET,
    NS_DIV
  } mvna_norm_state_e;

  // One normalised result.
  typedef struct packed {
    logic signed [OutBits-1:0] nx;
    logic signed [OutBits-1:0] ny;
    logic signed [OutBits-1:0] nz;
    logic                      zero;
  } mvna_result_t;

endpackage

// ===== src/mvna_normaliser.sv =====
// ============================================================================
// Mesh vertex normal accumulator normaliser
// Scales a three-component sum to unit length using a shared squarer,
// a digit-serial square root and a bit-serial divider.
// ============================================================================
module mvna_normaliser
  import mvna_pkg::*;
#(
  parameter int unsigned SUM_BITS         = SumBitsDef,
  parameter int unsigned NORMAL_FRAC_BITS = NormalFracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [3*SUM_BITS-1:0] sum_i,
  output logic                  done_o,
  output mvna_result_t          res_o
);

  localparam int unsigned S    = SUM_BITS;
  localparam int unsigned F    = NORMAL_FRAC_BITS;
  localparam int unsigned NumW = NormBits + 1 + F;
  localparam int unsigned QW   = F + 2;
  localparam int unsigned CW   = $clog2(NumW + 1);
  localparam logic [S-1:0] HiLim = S'(64'd1 << NormBits);
  localparam logic [S-1:0] LoLim = S'(64'd1 << (NormBits - 1));

  mvna_norm_state_e state_q, state_d;

  logic [S-1:0]          m_q [3];
  logic [S-1:0]          mx_q;
  logic [2:0]            sign_q;
  logic [CW-1:0]         cnt_q;
  logic [1:0]            k_q;
  logic [2*NormBits-1:0] prod_q;
  logic [SqBits-1:0]     sq_q;
  logic [SqBits-1:0]     sqin_q;
  logic [RootBits+1:0]   srem_q;
  logic [RootBits-1:0]   root_q;
  logic [NumW-1:0]       num_q;
  logic [RootBits+1:0]   drem_q;
  logic [QW-1:0]         quo_q;
  logic                  done_q;
  mvna_result_t          res_q;

  // Magnitudes and largest magnitude of the incoming sum.
  logic [S-1:0] mag_in [3];
  logic [S-1:0] mx_in;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_in[k] = sum_i[k*S + S - 1] ? (~sum_i[k*S +: S] + S'(1)) : sum_i[k*S +: S];
    end
    mx_in = mag_in[0];
    if (mag_in[1] > mx_in) mx_in = mag_in[1];
    if (mag_in[2] > mx_in) mx_in = mag_in[2];
  end

  // One square root digit step.
  logic [RootBits+1:0] s_sh, s_trial;
  logic                s_ge;
  assign s_sh    = {srem_q[RootBits-1:0], sqin_q[SqBits-1 -: 2]};
  assign s_trial = {root_q, 2'b01};
  assign s_ge    = (s_sh >= s_trial);

  // One divider step.
  logic [RootBits+1:0] d_sh, d_len;
  logic                d_ge;
  logic [QW-1:0]       quo_nxt;
  logic [63:0]         q64, q_signed;
  assign d_sh     = {drem_q[RootBits:0], num_q[NumW-1]};
  assign d_len    = {2'b00, root_q};
  assign d_ge     = (d_sh >= d_len);
  assign quo_nxt  = {quo_q[QW-2:0], d_ge};
  assign q64      = 64'(quo_nxt);
  assign q_signed = sign_q[k_q] ? (64'd0 - q64) : q64;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      NS_IDLE: begin
        if (start_i && (mx_in != '0)) state_d = NS_NORM;
      end
      NS_NORM: begin
        if ((mx_q < HiLim) && (mx_q >= LoLim)) state_d = NS_SQ;
      end
      NS_SQ: begin
        if (cnt_q == CW'(3)) state_d = NS_SQRT;
      end
      NS_SQRT: begin
        if (cnt_q == CW'(RootBits - 1)) state_d = NS_DIV_SET;
      end
      NS_DIV_SET: state_d = NS_DIV;
      NS_DIV: begin
        if (cnt_q == CW'(NumW - 1)) state_d = (k_q == 2'd2) ? NS_IDLE : NS_DIV_SET;
      end
      default: state_d = NS_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NS_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        NS_IDLE: begin
          cnt_q <= '0;
          k_q   <= '0;
          if (start_i && (mx_in == '0)) done_q <= 1'b1;
        end
        NS_SQ: cnt_q <= (cnt_q == CW'(3)) ? '0 : cnt_q + CW'(1);
        NS_SQRT: cnt_q <= (cnt_q == CW'(RootBits - 1)) ? '0 : cnt_q + CW'(1);
        NS_DIV_SET: cnt_q <= '0;
        NS_DIV: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(NumW - 1)) begin
            k_q <= k_q + 2'd1;
            if (k_q == 2'd2) done_q <= 1'b1;
          end
        end
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      NS_IDLE: begin
        if (start_i) begin
          for (int k = 0; k < 3; k++) begin
            m_q[k]    <= mag_in[k];
            sign_q[k] <= sum_i[k*S + S - 1];
          end
          mx_q <= mx_in;
          sq_q <= '0;
          if (mx_in == '0) begin
            res_q <= '{nx: '0, ny: '0, nz: '0, zero: 1'b1};
          end
        end
      end
      NS_NORM: begin
        if (mx_q >= HiLim) begin
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
          mx_q <= mx_q >> 1;
        end else if (mx_q < LoLim) begin
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
          mx_q <= mx_q << 1;
        end
      end
      NS_SQ: begin
        if (cnt_q < CW'(3)) begin
          prod_q <= m_q[cnt_q[1:0]][NormBits-1:0] * m_q[cnt_q[1:0]][NormBits-1:0];
        end
        if (cnt_q != '0) sq_q <= sq_q + SqBits'(prod_q);
        srem_q <= '0;
        root_q <= '0;
        sqin_q <= sq_q + SqBits'(prod_q);
      end
      NS_SQRT: begin
        srem_q <= s_ge ? (s_sh - s_trial) : s_sh;
        root_q <= {root_q[RootBits-2:0], s_ge};
        sqin_q <= sqin_q << 2;
      end
      NS_DIV_SET: begin
        num_q  <= (NumW'(m_q[k_q][NormBits-1:0]) << F) + NumW'(root_q >> 1);
        drem_q <= '0;
        quo_q  <= '0;
      end
      NS_DIV: begin
        drem_q <= d_ge ? (d_sh - d_len) : d_sh;
        num_q  <= num_q << 1;
        quo_q  <= quo_nxt;
        if (cnt_q == CW'(NumW - 1)) begin
          res_q.zero <= 1'b0;
          case (k_q)
            2'd0:    res_q.nx <= q_signed[OutBits-1:0];
            2'd1:    res_q.ny <= q_signed[OutBits-1:0];
            default: res_q.nz <= q_signed[OutBits-1:0];
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== src/mesh_vertex_normal_accumulator.sv =====
// ============================================================================
// Mesh vertex normal accumulator
// Stores vertex positions, accumulates area-weighted face normals per vertex
// and returns unit normals on request.
// ============================================================================
// Items arrive on a valid/ready input channel; each transfer carries an
// opcode: load a position (and clear its sum), add a triangle, or read a
// vertex normal. Only a read produces a result, on the valid/ready output
// channel, as three signed Q1.F components and a zero-length flag.
// One item is processed at a time; ready is high while the sequencer idles.
// A triangle runs three position reads, six products through one shared
// multiplier, and a read-modify-write of each corner's sum in the sum memory.
// A read scales the sum by one-bit shifts (at most 29 with the default
// widths) and then normalises it; the square root and the divider each
// settle one bit per cycle. A read of a zero sum skips these steps.
// The output register holds a result until it is taken; a new item is
// accepted meanwhile, but a further read result waits while it stalls.
// Reset clears the sequencer and the output valid; memory contents are
// undefined until each vertex is loaded.
// ============================================================================
module mesh_vertex_normal_accumulator
  import mvna_pkg::*;
#(
  parameter int unsigned MAX_VERTICES     = MaxVerticesDef,
  parameter int unsigned COORD_BITS       = CoordBitsDef,
  parameter int unsigned SUM_BITS         = SumBitsDef,
  parameter int unsigned NORMAL_FRAC_BITS = NormalFracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [OpBits-1:0]         opcode_i,
  input  logic [IndexBits-1:0]      vertex_index_i,
  input  logic signed [PosBits-1:0] pos_x_i,
  input  logic signed [PosBits-1:0] pos_y_i,
  input  logic signed [PosBits-1:0] pos_z_i,
  input  logic [IndexBits-1:0]      corner_a_i,
  input  logic [IndexBits-1:0]      corner_b_i,
  input  logic [IndexBits-1:0]      corner_c_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [OutBits-1:0] normal_x_o,
  output logic signed [OutBits-1:0] normal_y_o,
  output logic signed [OutBits-1:0] normal_z_o,
  output logic                      zero_length_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned S  = SUM_BITS;
  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned EW = C + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned NW = PW + 1;
  localparam int unsigned W  = ((S > NW) ? S : NW) + 2;
  localparam logic signed [W-1:0] SumMax = {{(W - S + 1){1'b0}}, {(S - 1){1'b1}}};
  localparam logic signed [W-1:0] SumMin = ~SumMax;

  mvna_state_e state_q, state_d;

  // Latched item.
  logic [OpBits-1:0] op_q;
  logic [AW-1:0]     idx_q, ca_q, cb_q, cc_q;
  logic [C-1:0]      px_q, py_q, pz_q;
  logic [2:0]        cnt_q;

  // Memories with registered read data.
  logic [3*C-1:0] pos_mem [MAX_VERTICES];
  logic [3*S-1:0] sum_mem [MAX_VERTICES];
  logic [3*C-1:0] pos_rdata_q;
  logic [3*S-1:0] sum_rdata_q;
  logic           pos_re, pos_we, sum_re, sum_we;
  logic [AW-1:0]  pos_addr, sum_addr;
  logic [3*C-1:0] pos_wdata;
  logic [3*S-1:0] sum_wdata;

  // Triangle datapath.
  logic signed [C-1:0]  pa_q [3];
  logic signed [C-1:0]  pb_q [3];
  logic signed [C-1:0]  pc_q [3];
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic signed [PW-1:0] prod_q;
  logic signed [NW-1:0] n_q [3];

  // Output register.
  logic         out_valid_q;
  mvna_result_t out_q;

  // Normaliser.
  logic         norm_start, norm_done;
  mvna_result_t norm_res;

  // Range checks on the incoming indices.
  logic idx_ok, tri_ok, accept;
  assign idx_ok = (32'(vertex_index_i) < MAX_VERTICES);
  assign tri_ok = (32'(corner_a_i) < MAX_VERTICES) && (32'(corner_b_i) < MAX_VERTICES) &&
                  (32'(corner_c_i) < MAX_VERTICES);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Corner chosen by the step counter.
  logic [AW-1:0] corner_sel;
  always_comb begin
    case (cnt_q)
      3'd0:    corner_sel = ca_q;
      3'd1:    corner_sel = cb_q;
      default: corner_sel = cc_q;
    endcase
  end

  // Multiplier operand selection for the six cross product terms.
  logic signed [EW-1:0] mul_a, mul_b;
  always_comb begin
    case (cnt_q)
      3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
      3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
      3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
      3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
      3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
      default: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
    endcase
  end

  // Saturating accumulation of the face normal into a stored sum.
  logic signed [W-1:0] acc [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = W'($signed(sum_rdata_q[k*S +: S])) + W'(n_q[k]);
      if (acc[k] > SumMax) acc[k] = SumMax;
      else if (acc[k] < SumMin) acc[k] = SumMin;
      sum_wdata[k*S +: S] = acc[k][S-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((opcode_i == OpLoad) && idx_ok) state_d = ST_LOAD;
          else if ((opcode_i == OpTriangle) && tri_ok) state_d = ST_TRI_RD;
          else if ((opcode_i == OpRead) && idx_ok) state_d = ST_RD_SUM;
        end
      end
      ST_LOAD: state_d = ST_IDLE;
      ST_TRI_RD: if (cnt_q == 3'd3) state_d = ST_TRI_EDGE;
      ST_TRI_EDGE: state_d = ST_TRI_MUL;
      ST_TRI_MUL: if (cnt_q == 3'd6) state_d = ST_RMW_RD;
      ST_RMW_RD: state_d = ST_RMW_WR;
      ST_RMW_WR: state_d = (cnt_q == 3'd2) ? ST_IDLE : ST_RMW_RD;
      ST_RD_SUM: state_d = ST_RD_START;
      ST_RD_START: state_d = ST_RD_WAIT;
      ST_RD_WAIT: if (norm_done) state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    pos_re     = 1'b0;
    pos_we     = 1'b0;
    sum_re     = 1'b0;
    sum_we     = 1'b0;
    pos_addr   = idx_q;
    sum_addr   = idx_q;
    pos_wdata  = {pz_q, py_q, px_q};
    norm_start = 1'b0;
    case (state_q)
      ST_LOAD: begin
        pos_we = 1'b1;
        sum_we = 1'b1;
      end
      ST_TRI_RD: begin
        pos_re   = (cnt_q < 3'd3);
        pos_addr = corner_sel;
      end
      ST_RMW_RD: begin
        sum_re   = 1'b1;
        sum_addr = corner_sel;
      end
      ST_RMW_WR: begin
        sum_we   = 1'b1;
        sum_addr = corner_sel;
      end
      ST_RD_SUM: sum_re = 1'b1;
      ST_RD_START: norm_start = 1'b1;
      default: begin
      end
    endcase
  end

  // Position memory.
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_addr] <= pos_wdata;
    if (pos_re) pos_rdata_q <= pos_mem[pos_addr];
  end

  // Sum memory; a load clears the sum of its vertex.
  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_addr] <= (state_q == ST_LOAD) ? '0 : sum_wdata;
    if (sum_re) sum_rdata_q <= sum_mem[sum_addr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_DONE) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: cnt_q <= '0;
        ST_TRI_RD: cnt_q <= (cnt_q == 3'd3) ? '0 : cnt_q + 3'd1;
        ST_TRI_MUL: cnt_q <= (cnt_q == 3'd6) ? '0 : cnt_q + 3'd1;
        ST_RMW_WR: cnt_q <= cnt_q + 3'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Item capture and triangle datapath.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      idx_q <= AW'(vertex_index_i);
      ca_q  <= AW'(corner_a_i);
      cb_q  <= AW'(corner_b_i);
      cc_q  <= AW'(corner_c_i);
      px_q  <= C'($unsigned(pos_x_i));
      py_q  <= C'($unsigned(pos_y_i));
      pz_q  <= C'($unsigned(pos_z_i));
    end
    case (state_q)
      ST_TRI_RD: begin
        for (int k = 0; k < 3; k++) begin
          if (cnt_q == 3'd1) pa_q[k] <= $signed(pos_rdata_q[k*C +: C]);
          if (cnt_q == 3'd2) pb_q[k] <= $signed(pos_rdata_q[k*C +: C]);
          if (cnt_q == 3'd3) pc_q[k] <= $signed(pos_rdata_q[k*C +: C]);
        end
      end
      ST_TRI_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1_q[k] <= EW'(pb_q[k]) - EW'(pa_q[k]);
          e2_q[k] <= EW'(pc_q[k]) - EW'(pa_q[k]);
        end
      end
      ST_TRI_MUL: begin
        if (cnt_q < 3'd6) prod_q <= mul_a * mul_b;
        case (cnt_q)
          3'd1: n_q[0] <= NW'(prod_q);
          3'd2: n_q[0] <= n_q[0] - NW'(prod_q);
          3'd3: n_q[1] <= NW'(prod_q);
          3'd4: n_q[1] <= n_q[1] - NW'(prod_q);
          3'd5: n_q[2] <= NW'(prod_q);
          3'd6: n_q[2] <= n_q[2] - NW'(prod_q);
          default: begin
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) out_q <= norm_res;
      end
      default: begin
      end
    endcase
  end

  // Unit normal from the stored sum.
  mvna_normaliser #(
    .SUM_BITS        (SUM_BITS),
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_normaliser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(norm_start && (op_q == OpRead)),
    .sum_i  (sum_rdata_q),
    .done_o (norm_done),
    .res_o  (norm_res)
  );

  assign out_valid_o   = out_valid_q;
  assign normal_x_o    = out_q.nx;
  assign normal_y_o    = out_q.ny;
  assign normal_z_o    = out_q.nz;
  assign zero_length_o = out_q.zero;

endmodule

// ===== dv/mvna_normal_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Mesh vertex normal checker
// Watches both channels of the accumulator, keeps its own copy of the
// position and sum stores, predicts each read result and compares it.
// ============================================================================
module mvna_normal_checker
  import mvna_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [OpBits-1:0]         opcode_i,
  input  logic [IndexBits-1:0]      vertex_index_i,
  input  logic signed [PosBits-1:0] pos_x_i,
  input  logic signed [PosBits-1:0] pos_y_i,
  input  logic signed [PosBits-1:0] pos_z_i,
  input  logic [IndexBits-1:0]      corner_a_i,
  input  logic [IndexBits-1:0]      corner_b_i,
  input  logic [IndexBits-1:0]      corner_c_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [OutBits-1:0] normal_x_i,
  input  logic signed [OutBits-1:0] normal_y_i,
  input  logic signed [OutBits-1:0] normal_z_i,
  input  logic                      zero_length_i,
  output int                        errors_o,
  output int                        pending_o,
  output int                        normals_seen_o,
  output int                        zero_seen_o
);

  localparam longint SumMax = (64'sd1 <<< (SumBitsDef - 1)) - 1;
  localparam longint SumMin = -SumMax - 1;

  // Model of the stores, one entry per vertex.
  longint       vert_pos [MaxVerticesDef][3];
  longint       vert_sum [MaxVerticesDef][3];
  mvna_result_t normals_due[$];
  int           error_count;
  int           normal_count;
  int           zero_count;

  assign errors_o       = error_count;
  assign pending_o      = normals_due.size();
  assign normals_seen_o = normal_count;
  assign zero_seen_o    = zero_count;

  initial begin
    error_count  = 0;
    normal_count = 0;
    zero_count   = 0;
  end

  // Prints one line per mismatch and counts it.
  task automatic report(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    error_count++;
  endtask

  function automatic longint sat_sum(input longint acc, input longint addend);
    longint total;
    total = acc + addend;
    if (total > SumMax) return SumMax;
    if (total < SumMin) return SumMin;
    return total;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scales a sum to unit length with rounding half away from zero.
  function automatic mvna_result_t unit_normal(input int unsigned vi);
    mvna_result_t    res;
    longint unsigned mag [3];
    longint unsigned peak;
    longint unsigned len;
    longint unsigned q;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (vert_sum[vi][k] < 0) ? -vert_sum[vi][k] : vert_sum[vi][k];
    end
    peak = mag[0];
    if (mag[1] > peak) peak = mag[1];
    if (mag[2] > peak) peak = mag[2];
    res = '0;
    if (peak == 0) begin
      res.zero = 1'b1;
      return res;
    end
    while (peak >= (64'd1 << 30)) begin
      for (int k = 0; k < 3; k++) mag[k] >>= 1;
      peak >>= 1;
    end
    while (peak < (64'd1 << 29)) begin
      for (int k = 0; k < 3; k++) mag[k] <<= 1;
      peak <<= 1;
    end
    len = floor_root(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << NormalFracBitsDef) + (len >> 1)) / len;
      if (vert_sum[vi][k] < 0) q = -q;
      case (k)
        0: res.nx = q[OutBits-1:0];
        1: res.ny = q[OutBits-1:0];
        default: res.nz = q[OutBits-1:0];
      endcase
    end
    return res;
  endfunction

  // Applies one accepted item to the model.
  always @(posedge clk_i) begin
    longint edge1 [3];
    longint edge2 [3];
    longint face_n [3];
    int unsigned corners [3];
    if (rst_ni && in_valid_i && in_ready_i) begin
      case (opcode_i)
        OpLoad: begin
          vert_pos[vertex_index_i][0] = longint'(pos_x_i);
          vert_pos[vertex_index_i][1] = longint'(pos_y_i);
          vert_pos[vertex_index_i][2] = longint'(pos_z_i);
          for (int k = 0; k < 3; k++) vert_sum[vertex_index_i][k] = 0;
        end
        OpTriangle: begin
          corners[0] = 32'(corner_a_i);
          corners[1] = 32'(corner_b_i);
          corners[2] = 32'(corner_c_i);
          for (int k = 0; k < 3; k++) begin
            edge1[k] = vert_pos[corners[1]][k] - vert_pos[corners[0]][k];
            edge2[k] = vert_pos[corners[2]][k] - vert_pos[corners[0]][k];
          end
          face_n[0] = edge1[1] * edge2[2] - edge1[2] * edge2[1];
          face_n[1] = edge1[2] * edge2[0] - edge1[0] * edge2[2];
          face_n[2] = edge1[0] * edge2[1] - edge1[1] * edge2[0];
          // A repeated corner receives the product once per appearance.
          for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
              vert_sum[corners[c]][k] = sat_sum(vert_sum[corners[c]][k], face_n[k]);
            end
          end
        end
        OpRead: normals_due.insert(normals_due.size(), unit_normal(32'(vertex_index_i)));
        default: ;
      endcase
    end
  end

  // Compares each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    mvna_result_t want;
    if (rst_ni && out_valid_i && out_ready_i) begin
      normal_count++;
      if (zero_length_i) zero_count++;
      if (normals_due.size() == 0) begin
        report("result transfer with no read outstanding");
      end else begin
        want = normals_due.pop_front();
        if (normal_x_i !== want.nx)
          report($sformatf("normal_x got %0d want %0d", normal_x_i, want.nx));
        if (normal_y_i !== want.ny)
          report($sformatf("normal_y got %0d want %0d", normal_y_i, want.ny));
        if (normal_z_i !== want.nz)
          report($sformatf("normal_z got %0d want %0d", normal_z_i, want.nz));
        if (zero_length_i !== want.zero)
          report($sformatf("zero_length got %0b want %0b", zero_length_i, want.zero));
      end
    end
  end

endmodule

// ===== dv/mesh_vertex_normal_accumulator_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Mesh vertex normal accumulator testbench
// Drives loads, triangles and reads with random gaps and output stalls; a
// separate checker predicts every normal and this top gives the verdict.
// ============================================================================
module mesh_vertex_normal_accumulator_test;
  import mvna_pkg::*;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid;
  logic                      in_ready;
  logic [OpBits-1:0]         opcode;
  logic [IndexBits-1:0]      vertex_index;
  logic signed [PosBits-1:0] pos_x;
  logic signed [PosBits-1:0] pos_y;
  logic signed [PosBits-1:0] pos_z;
  logic [IndexBits-1:0]      corner_a;
  logic [IndexBits-1:0]      corner_b;
  logic [IndexBits-1:0]      corner_c;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [OutBits-1:0] normal_x;
  logic signed [OutBits-1:0] normal_y;
  logic signed [OutBits-1:0] normal_z;
  logic                      zero_length;
  int                        error_count;
  int                        pending_reads;
  int                        normals_seen;
  int                        zero_seen;

  // Vertices that hold a position; only these are used by triangles and reads.
  bit                        loaded [MaxVerticesDef];
  int unsigned               loaded_list[$];
  int                        burst_left;
  int                        stall_mode = 0;
  int                        stall_left = 0;

  mesh_vertex_normal_accumulator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .opcode_i      (opcode),
    .vertex_index_i(vertex_index),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .pos_z_i       (pos_z),
    .corner_a_i    (corner_a),
    .corner_b_i    (corner_b),
    .corner_c_i    (corner_c),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .normal_x_o    (normal_x),
    .normal_y_o    (normal_y),
    .normal_z_o    (normal_z),
    .zero_length_o (zero_length)
  );

  mvna_normal_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .opcode_i      (opcode),
    .vertex_index_i(vertex_index),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .pos_z_i       (pos_z),
    .corner_a_i    (corner_a),
    .corner_b_i    (corner_b),
    .corner_c_i    (corner_c),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .normal_x_i    (normal_x),
    .normal_y_i    (normal_y),
    .normal_z_i    (normal_z),
    .zero_length_i (zero_length),
    .errors_o      (error_count),
    .pending_o     (pending_reads),
    .normals_seen_o(normals_seen),
    .zero_seen_o   (zero_seen)
  );

  // Clock with an 8 ns period.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Receiver stalls: modes of full speed, random refusal and long stalls.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 19) == 0);
    endcase
  end

  // Presents one item and waits for its transfer; valid stays high after.
  task automatic send(input logic [OpBits-1:0] op, input int unsigned vi,
                      input int px, input int py, input int pz,
                      input int unsigned ca, input int unsigned cb,
                      input int unsigned cc);
    in_valid     <= 1'b1;
    opcode       <= op;
    vertex_index <= IndexBits'(vi);
    pos_x        <= PosBits'(px);
    pos_y        <= PosBits'(py);
    pos_z        <= PosBits'(pz);
    corner_a     <= IndexBits'(ca);
    corner_b     <= IndexBits'(cb);
    corner_c     <= IndexBits'(cc);
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (op == OpLoad && !loaded[vi]) begin
      loaded[vi] = 1'b1;
      loaded_list.insert(loaded_list.size(), vi);
    end
  endtask

  // Ends a burst with a random gap now and then.
  task automatic maybe_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic drain_reads();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_reads != 0) @(posedge clk_i);
  endtask

  function automatic int pick_coord();
    if ($urandom_range(0, 3) == 0) return $signed(16'($urandom));
    return $signed(16'($urandom_range(0, 4000))) - 2000;
  endfunction

  function automatic int unsigned pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // Generous bound on the whole run.
  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned roll;
    int unsigned vi;
    in_valid     <= 1'b0;
    opcode       <= OpLoad;
    vertex_index <= '0;
    pos_x        <= '0;
    pos_y        <= '0;
    pos_z        <= '0;
    corner_a     <= '0;
    corner_b     <= '0;
    corner_c     <= '0;
    out_ready    <= 1'b0;
    burst_left   = 0;
    rst_ni       <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme positions, the highest index and a zero-length read.
    send(OpLoad, 0, -32768, -32768, 0, 0, 0, 0);
    send(OpLoad, 1, 32767, -32768, 0, 0, 0, 0);
    send(OpLoad, 2, -32768, 32767, 0, 0, 0, 0);
    send(OpLoad, 1023, 32767, 32767, 32767, 1023, 1023, 1023);
    send(OpRead, 1023, 0, 0, 0, 0, 0, 0);
    send(OpTriangle, 0, 0, 0, 0, 0, 1, 2);
    send(OpRead, 0, 0, 0, 0, 0, 0, 0);
    send(OpTriangle, 0, 0, 0, 0, 1023, 0, 2);
    send(OpTriangle, 0, 0, 0, 0, 1, 1, 2);
    send(OpTriangle, 0, 0, 0, 0, 2, 2, 2);
    send(OpRead, 1, 0, 0, 0, 0, 0, 0);
    send(OpRead, 1023, 0, 0, 0, 0, 0, 0);
    // Unused opcode with every field set: nothing must happen.
    send(2'd3, 1023, -1, -1, -1, 1023, 1023, 1023);
    send(OpRead, 2, 0, 0, 0, 0, 0, 0);
    // Reloading a vertex clears its sum.
    send(OpLoad, 1, 32767, -32768, 0, 0, 0, 0);
    send(OpRead, 1, 0, 0, 0, 0, 0, 0);
    drain_reads();

    // Large sums: the largest face product added repeatedly in both windings.
    for (int n = 0; n < 30; n++) send(OpTriangle, 0, 0, 0, 0, 0, 1, 2);
    for (int n = 0; n < 10; n++) send(OpTriangle, 0, 0, 0, 0, 0, 2, 1);
    send(OpRead, 0, 0, 0, 0, 0, 0, 0);
    send(OpRead, 2, 0, 0, 0, 0, 0, 0);
    drain_reads();

    // Random traffic over a small working set, with full-range indices now and then.
    for (int n = 0; n < 900; n++) begin
      if (n == 450) drain_reads();
      roll = $urandom_range(0, 99);
      if (roll < 30 || loaded_list.size() < 3) begin
        vi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31);
        send(OpLoad, vi, pick_coord(), pick_coord(), pick_coord(),
             $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
      end else if (roll < 68) begin
        vi = pick_loaded();
        send(OpTriangle, $urandom_range(0, 1023), $urandom, $urandom, $urandom,
             vi, ($urandom_range(0, 9) == 0) ? vi : pick_loaded(), pick_loaded());
      end else if (roll < 95) begin
        send(OpRead, pick_loaded(), $urandom, $urandom, $urandom,
             $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
      end else begin
        send(2'd3, $urandom_range(0, 1023), $urandom, $urandom, $urandom,
             $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      maybe_gap();
    end

    drain_reads();
    repeat (400) @(posedge clk_i);
    $display("Covered %0d vertices loaded, large sums and mixed traffic under stalls.",
             loaded_list.size());
    $display("Checked %0d normals, %0d of them zero length.", normals_seen, zero_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
